// ----- rtl/imurp_pkg.sv -----
`timescale 1ns / 1ps

package imurp_pkg;

  localparam int unsigned DefCordicSteps = 16;
  localparam int unsigned QueueDepth     = 2;

  localparam int unsigned AccW   = 34;  // aligned accelerometer, Q.14 counts
  localparam int unsigned GyrW   = 35;  // aligned gyro, LSB 2^-25 rad/s
  localparam int unsigned DeltaW = 32;  // gyro angle step, LSB 2^-24 rad
  localparam int unsigned EstW   = 32;  // angle estimate, LSB 2^-24 rad
  localparam int unsigned AngW   = 28;  // CORDIC angle accumulator
  localparam int unsigned CordW  = 54;  // CORDIC x/y datapath

  localparam logic signed [AngW-1:0] HalfPiQ24  = AngW'(26353589);
  localparam logic [29:0]            InvGainQ30 = 30'd652032874;

  typedef struct packed {
    logic signed [AccW-1:0]   aa0;
    logic signed [AccW-1:0]   aa1;
    logic signed [AccW-1:0]   aa2;
    logic signed [DeltaW-1:0] d_roll;
    logic signed [DeltaW-1:0] d_pitch;
  } item_t;

  // atan(2^-i) in 2^-24 rad
  function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      5'd0:  r = AngW'(13176795);
      5'd1:  r = AngW'(7778716);
      5'd2:  r = AngW'(4110060);
      5'd3:  r = AngW'(2086331);
      5'd4:  r = AngW'(1047214);
      5'd5:  r = AngW'(524117);
      5'd6:  r = AngW'(262123);
      5'd7:  r = AngW'(131069);
      5'd8:  r = AngW'(65536);
      5'd9:  r = AngW'(32768);
      5'd10: r = AngW'(16384);
      5'd11: r = AngW'(8192);
      5'd12: r = AngW'(4096);
      5'd13: r = AngW'(2048);
      5'd14: r = AngW'(1024);
      5'd15: r = AngW'(512);
      5'd16: r = AngW'(256);
      5'd17: r = AngW'(128);
      5'd18: r = AngW'(64);
      5'd19: r = AngW'(32);
      5'd20: r = AngW'(16);
      5'd21: r = AngW'(8);
      5'd22: r = AngW'(4);
      5'd23: r = AngW'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/imurp_front.sv -----
`timescale 1ns / 1ps

module imurp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [111:0]         in_data_i,
  input  logic [47:0]          row0_i,
  input  logic [47:0]          row1_i,
  input  logic [47:0]          row2_i,
  input  logic [47:0]          bias_i,
  output logic                 push_o,
  output imurp_pkg::item_t     item_o,
  input  logic                 full_i
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MAC  = 5'b00010,
    F_DT0  = 5'b00100,
    F_DT1  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e state_q, state_d;

  logic signed [15:0] acc_q [3];
  logic signed [15:0] rate_q [3];
  logic [15:0]        dt_q;
  logic [1:0]         row_q, col_q;
  logic signed [imurp_pkg::AccW-1:0]   aa_q [3];
  logic signed [imurp_pkg::GyrW-1:0]   ag_q [2];
  logic signed [imurp_pkg::DeltaW-1:0] d_roll_q, d_pitch_q;

  logic [47:0]        rsel;
  logic signed [15:0] m;
  logic signed [16:0] gyr;
  logic signed [31:0] pa;
  logic signed [32:0] pg;
  logic signed [imurp_pkg::GyrW-1:0] ag_sel;
  logic signed [51:0] pdt, rnd;

  always_comb begin
    case (row_q)
      2'd0:    rsel = row0_i;
      2'd1:    rsel = row1_i;
      default: rsel = row2_i;
    endcase
    m   = $signed(rsel[{col_q, 4'b0000} +: 16]);
    gyr = {rate_q[col_q][15], rate_q[col_q]}
        - $signed({bias_i[{col_q, 4'b0000} + 6'd15], bias_i[{col_q, 4'b0000} +: 16]});
    pa  = m * acc_q[col_q];
    pg  = m * gyr;
    ag_sel = state_q == F_DT0 ? ag_q[0] : ag_q[1];
    pdt = ag_sel * $signed({1'b0, dt_q});
    rnd = pdt + 52'sd1048576;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_MAC;
      F_MAC:   if (row_q == 2'd2 && col_q == 2'd2) state_d = F_DT0;
      F_DT0:   state_d = F_DT1;
      F_DT1:   state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        acc_q[0]  <= $signed(in_data_i[15:0]);
        acc_q[1]  <= $signed(in_data_i[31:16]);
        acc_q[2]  <= $signed(in_data_i[47:32]);
        rate_q[0] <= $signed(in_data_i[63:48]);
        rate_q[1] <= $signed(in_data_i[79:64]);
        rate_q[2] <= $signed(in_data_i[95:80]);
        dt_q      <= in_data_i[111:96];
        row_q     <= 2'd0;
        col_q     <= 2'd0;
        aa_q[0]   <= '0;
        aa_q[1]   <= '0;
        aa_q[2]   <= '0;
        ag_q[0]   <= '0;
        ag_q[1]   <= '0;
      end
      F_MAC: begin
        aa_q[row_q] <= aa_q[row_q] + imurp_pkg::AccW'(pa);
        if (row_q != 2'd2) begin
          ag_q[row_q[0]] <= ag_q[row_q[0]] + imurp_pkg::GyrW'(pg);
        end
        if (col_q == 2'd2) begin
          col_q <= 2'd0;
          row_q <= row_q + 2'd1;
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
      F_DT0:   d_roll_q  <= {rnd[51], rnd[51:21]};
      F_DT1:   d_pitch_q <= {rnd[51], rnd[51:21]};
      default: ;
    endcase
  end

  assign in_ready_o     = state_q == F_IDLE;
  assign push_o         = state_q == F_PUSH && !full_i;
  assign item_o.aa0     = aa_q[0];
  assign item_o.aa1     = aa_q[1];
  assign item_o.aa2     = aa_q[2];
  assign item_o.d_roll  = d_roll_q;
  assign item_o.d_pitch = d_pitch_q;

endmodule

// ----- rtl/imurp_queue.sv -----
`timescale 1ns / 1ps

module imurp_queue #(
  parameter int unsigned Depth = imurp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  imurp_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output imurp_pkg::item_t item_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  imurp_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i)  rd_q <= nxt(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign item_o  = mem_q[rd_q];
  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;

endmodule

// ----- rtl/imurp_back.sv -----
`timescale 1ns / 1ps

module imurp_back #(
  parameter int unsigned CordicSteps = imurp_pkg::DefCordicSteps
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  imurp_pkg::item_t item_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic [15:0]      alpha_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [15:0]      roll_o,
  output logic [15:0]      pitch_o
);

  localparam int unsigned CW = imurp_pkg::CordW;
  localparam int unsigned AW = imurp_pkg::AngW;
  localparam int unsigned EW = imurp_pkg::EstW;
  localparam int unsigned DW = imurp_pkg::DeltaW;
  localparam int unsigned SW = $clog2(CordicSteps);

  typedef enum logic [9:0] {
    B_IDLE  = 10'b0000000001,
    B_ROLL  = 10'b0000000010,
    B_GHI   = 10'b0000000100,
    B_GLO   = 10'b0000001000,
    B_PITCH = 10'b0000010000,
    B_BRA   = 10'b0000100000,
    B_BRB   = 10'b0001000000,
    B_BPA   = 10'b0010000000,
    B_BPB   = 10'b0100000000,
    B_OUT   = 10'b1000000000
  } bstate_e;

  bstate_e state_q, state_d;

  logic signed [imurp_pkg::AccW-1:0] aa0_q;
  logic signed [DW-1:0] d_roll_q, d_pitch_q;
  logic signed [CW-1:0] x_q, y_q, x_d, y_d, lx, ly, dx, dy;
  logic signed [AW-1:0] ang_q, ang_d, lang, tab;
  logic                 zero_q, lzero, load;
  logic [SW-1:0]        step_q;
  logic signed [CW-1:0] mag_q;
  logic signed [AW-1:0] tilt_roll_q, tilt_pitch_q, acc_sel;
  logic [61:0]          prod_q, gsum;
  logic [49:0]          plo;
  logic signed [44:0]   p1_q;
  logic signed [EW-1:0] roll_est_q, pitch_est_q, est_sel, blend_res;
  logic signed [DW-1:0] d_sel;
  logic signed [32:0]   g;
  logic signed [17:0]   w;
  logic signed [50:0]   p2;
  logic signed [52:0]   s;
  logic                 last_step, out_take;
  logic                 out_valid_q;
  logic [15:0]          roll_q, pitch_q;

  function automatic logic [15:0] to_out(input logic signed [EW-1:0] e);
    logic signed [32:0] t;
    t = {e[EW-1], e} + 33'sd1024;
    if (t[32:26] == 7'h00 || t[32:26] == 7'h7f) return t[26:11];
    return t[32] ? 16'h8000 : 16'h7fff;
  endfunction

  // seed of a vectoring run, with the quarter-turn pre-rotation
  always_comb begin
    lx = '0;
    ly = '0;
    if (state_q == B_IDLE) begin
      lx = {{(CW-imurp_pkg::AccW-16){item_i.aa2[imurp_pkg::AccW-1]}}, item_i.aa2, 16'h0000};
      ly = {{(CW-imurp_pkg::AccW-16){item_i.aa1[imurp_pkg::AccW-1]}}, item_i.aa1, 16'h0000};
    end else begin
      lx = {2'b00, gsum[61:10]};
      ly = {{(CW-imurp_pkg::AccW-16){aa0_q[imurp_pkg::AccW-1]}}, aa0_q, 16'h0000};
    end
    lzero = lx == '0 && ly == '0;
    lang  = '0;
    if (lx[CW-1]) begin
      if (!ly[CW-1]) begin
        lang = imurp_pkg::HalfPiQ24;
        {lx, ly} = {ly, -lx};
      end else begin
        lang = -imurp_pkg::HalfPiQ24;
        {lx, ly} = {-ly, lx};
      end
    end
  end

  assign plo  = mag_q[19:0] * imurp_pkg::InvGainQ30;
  assign gsum = prod_q + {32'h0, plo[49:20]};

  // one CORDIC micro-rotation per cycle
  always_comb begin
    dx  = y_q >>> step_q;
    dy  = x_q >>> step_q;
    tab = imurp_pkg::atan_q24(5'(step_q));
    if (!y_q[CW-1]) begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      ang_d = ang_q + tab;
    end else begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      ang_d = ang_q - tab;
    end
  end

  assign last_step = step_q == SW'(CordicSteps - 1);

  // shared blend arithmetic
  always_comb begin
    acc_sel = (state_q == B_BRA) ? tilt_roll_q : tilt_pitch_q;
    est_sel = (state_q == B_BRB) ? roll_est_q : pitch_est_q;
    d_sel   = (state_q == B_BRB) ? d_roll_q : d_pitch_q;
    g  = {est_sel[EW-1], est_sel} + {d_sel[DW-1], d_sel};
    w  = 18'sd65536 - $signed({2'b00, alpha_i});
    p2 = w * g;
    s  = {{8{p1_q[44]}}, p1_q} + {{2{p2[50]}}, p2} + 53'sd32768;
    if (s[52:47] == 6'h00 || s[52:47] == 6'h3f) blend_res = s[47:16];
    else blend_res = s[52] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
  end

  assign out_take = !out_valid_q || out_ready_i;
  assign pop_o    = state_q == B_IDLE && !empty_i;
  assign load     = pop_o || state_q == B_GLO;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_ROLL;
      B_ROLL:  if (last_step) state_d = B_GHI;
      B_GHI:   state_d = B_GLO;
      B_GLO:   state_d = B_PITCH;
      B_PITCH: if (last_step) state_d = B_BRA;
      B_BRA:   state_d = B_BRB;
      B_BRB:   state_d = B_BPA;
      B_BPA:   state_d = B_BPB;
      B_BPB:   state_d = B_OUT;
      B_OUT:   if (out_take) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      roll_est_q  <= '0;
      pitch_est_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_BRB) roll_est_q  <= blend_res;
      if (state_q == B_BPB) pitch_est_q <= blend_res;
      if (state_q == B_OUT && out_take) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      aa0_q     <= item_i.aa0;
      d_roll_q  <= item_i.d_roll;
      d_pitch_q <= item_i.d_pitch;
    end
    if (load) begin
      x_q    <= lx;
      y_q    <= ly;
      ang_q  <= lang;
      zero_q <= lzero;
      step_q <= '0;
    end else if (state_q == B_ROLL || state_q == B_PITCH) begin
      x_q    <= x_d;
      y_q    <= y_d;
      ang_q  <= ang_d;
      step_q <= step_q + SW'(1);
    end
    if (state_q == B_ROLL && last_step) begin
      tilt_roll_q <= zero_q ? '0 : ang_d;
      mag_q       <= zero_q ? '0 : x_d;
    end
    if (state_q == B_PITCH && last_step) begin
      tilt_pitch_q <= zero_q ? '0 : -ang_d;
    end
    if (state_q == B_GHI) prod_q <= mag_q[51:20] * imurp_pkg::InvGainQ30;
    if (state_q == B_BRA || state_q == B_BPA) begin
      p1_q <= $signed({1'b0, alpha_i}) * acc_sel;
    end
    if (state_q == B_OUT && out_take) begin
      roll_q  <= to_out(roll_est_q);
      pitch_q <= to_out(pitch_est_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign roll_o      = roll_q;
  assign pitch_o     = pitch_q;

endmodule

// ----- rtl/imu_roll_pitch_complementary_top.sv -----
`timescale 1ns / 1ps

// Roll/pitch complementary filter for an IMU.
// Slave stream: one transfer per sample (accelerometer, gyro, time step).
// Master stream: one transfer per sample with filtered roll and pitch,
// Q2.13 radians, saturated. Yaw is not produced.
// APB port: 64-bit registers at 8*i: 0..2 alignment rows (three Q2.14
// entries each), 3 gyro bias x/y/z, 4 blend weight alpha (Q0.16).
// Front end: nine multiply-accumulates of the alignment matrix, two
// gyro*dt products and one hand-off per sample.
// Back end: two CORDIC vectoring runs on one shared iteration unit,
// gain correction in two steps, a two-step blend per angle and an
// output load per sample.
// Throughput is set by the back end.
// A two-entry queue lets the front take the next sample while the
// back end works. The output register holds the last result while the
// receiver stalls; the back end then waits in its final step.
// Reset clears both estimates and loads the identity matrix, zero bias
// and alpha = 6554.
module imu_roll_pitch_complementary_top #(
  parameter int unsigned CORDIC_STEPS = imurp_pkg::DefCordicSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, time_step (16 bits each)
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll, pitch (16 bits each)
  output logic [31:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] RegRow0   = 3'd0;
  localparam logic [2:0] RegRow1   = 3'd1;
  localparam logic [2:0] RegRow2   = 3'd2;
  localparam logic [2:0] RegBias   = 3'd3;
  localparam logic [2:0] RegWeight = 3'd4;

  logic [47:0] row0_q, row1_q, row2_q, bias_q;
  logic [15:0] alpha_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q  <= 48'h0000_0000_4000;
      row1_q  <= 48'h0000_4000_0000;
      row2_q  <= 48'h4000_0000_0000;
      bias_q  <= '0;
      alpha_q <= 16'd6554;
    end else if (wr_en) begin
      case (reg_idx)
        RegRow0:   row0_q  <= pwdata[47:0];
        RegRow1:   row1_q  <= pwdata[47:0];
        RegRow2:   row2_q  <= pwdata[47:0];
        RegBias:   bias_q  <= pwdata[47:0];
        RegWeight: alpha_q <= pwdata[15:0];
        default: ;  // no register here
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegRow0:   prdata = {16'h0, row0_q};
      RegRow1:   prdata = {16'h0, row1_q};
      RegRow2:   prdata = {16'h0, row2_q};
      RegBias:   prdata = {16'h0, bias_q};
      RegWeight: prdata = {48'h0, alpha_q};
      default:   prdata = '0;
    endcase
  end

  // front -> queue -> back
  imurp_pkg::item_t q_in, q_out;
  logic q_push, q_full, q_pop, q_empty;

  imurp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .row0_i     (row0_q),
    .row1_i     (row1_q),
    .row2_i     (row2_q),
    .bias_i     (bias_q),
    .push_o     (q_push),
    .item_o     (q_in),
    .full_i     (q_full)
  );

  imurp_queue #(
    .Depth (imurp_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  imurp_back #(
    .CordicSteps (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (q_out),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .alpha_i     (alpha_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .roll_o      (m_axis_tdata[15:0]),
    .pitch_o     (m_axis_tdata[31:16])
  );

  // queue never overflows or underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("pop from empty queue");
  // front end is busy in the cycle after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("front accepted back to back");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CordicSteps = 16;
  localparam logic signed [63:0] HalfPiQ24 = 64'sd26353589;
  localparam logic signed [63:0] InvGainQ30 = 64'sd652032874;

  // register indexes
  typedef enum int unsigned {
    RegAlignRow0 = 0,
    RegAlignRow1 = 1,
    RegAlignRow2 = 2,
    RegGyroBias  = 3,
    RegBlendW    = 4,
    RegUndef     = 5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] time_step;
    logic [15:0] rate_z;
    logic [15:0] rate_y;
    logic [15:0] rate_x;
    logic [15:0] acc_z;
    logic [15:0] acc_y;
    logic [15:0] acc_x;
  } sample_t;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] roll;
  } angles_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, time_step
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // roll, pitch
  logic [31:0]  m_axis_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [5:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  imu_roll_pitch_complementary_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------
  // Predictor state: shadow of the registers and the two estimates
  // ---------------------------------------------------------------------
  logic [47:0]        mdl_rows [3];
  logic [47:0]        mdl_bias;
  logic [15:0]        mdl_alpha;
  logic signed [31:0] mdl_roll_est;
  logic signed [31:0] mdl_pitch_est;

  sample_t pending_samples [$];  // waiting for the driver
  angles_t expected_angles [$];  // predicted, not yet seen on the master side

  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  bit          drv_hold;    // driver paused by the stimulus process
  int unsigned drv_gap;
  int unsigned rx_gap;

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return 64'(signed'(v));
  endfunction

  // floor shift of a signed value
  function automatic logic signed [63:0] fshr(input logic signed [63:0] v, input int n);
    return v >>> n;
  endfunction

  // CORDIC vectoring, returns angle in 2^-24 rad; magnitude through mag
  function automatic logic signed [63:0] cordic_atan(input logic signed [63:0] xi,
                                                     input logic signed [63:0] yi,
                                                     output logic signed [63:0] mag);
    logic signed [63:0] x, y, t, ang, dx, dy;
    logic signed [63:0] tab [24];
    tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
            65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
    x = xi;
    y = yi;
    ang = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    // left half plane: pre-rotate by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        ang = HalfPiQ24;
      end else begin
        x = -y;
        y = t;
        ang = -HalfPiQ24;
      end
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        ang += tab[i];
      end else begin
        x -= dx;
        y += dy;
        ang -= tab[i];
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic logic signed [31:0] blend_est(input logic signed [63:0] acc_ang,
                                                   input logic signed [31:0] prev,
                                                   input logic signed [63:0] delta);
    logic signed [63:0] a, g, v;
    a = 64'(mdl_alpha);
    g = 64'(prev) + delta;
    v = fshr(a * acc_ang + (64'sd65536 - a) * g + 64'sd32768, 16);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [15:0] est_to_q13(input logic signed [31:0] est);
    logic signed [63:0] v;
    v = fshr(64'(est) + 64'sd1024, 11);
    if (v > 64'sd32767) v = 64'sd32767;
    if (v < -64'sd32768) v = -64'sd32768;
    return v[15:0];
  endfunction

  // Advance the filter by one sample and return the expected angles.
  function automatic angles_t filter_step(input sample_t s);
    logic signed [63:0] acc [3], gyr [3], aa [3], ag [3], m;
    logic signed [63:0] mag, hi, lo, r, roll_tilt, pitch_tilt, d_roll, d_pitch, dt;
    angles_t res;
    acc[0] = sx16(s.acc_x);
    acc[1] = sx16(s.acc_y);
    acc[2] = sx16(s.acc_z);
    gyr[0] = sx16(s.rate_x) - sx16(mdl_bias[15:0]);
    gyr[1] = sx16(s.rate_y) - sx16(mdl_bias[31:16]);
    gyr[2] = sx16(s.rate_z) - sx16(mdl_bias[47:32]);
    dt = 64'(s.time_step);
    for (int i = 0; i < 3; i++) begin
      aa[i] = 0;
      ag[i] = 0;
      for (int j = 0; j < 3; j++) begin
        m = sx16(mdl_rows[i][16*j +: 16]);
        aa[i] += m * acc[j];
        ag[i] += m * gyr[j];
      end
    end
    roll_tilt = cordic_atan(aa[2] * 65536, aa[1] * 65536, mag);
    // gain correction split so the product stays in range
    hi = fshr(mag, 20);
    lo = mag & 64'hFFFFF;
    r = fshr(hi * InvGainQ30 + fshr(lo * InvGainQ30, 20), 10);
    pitch_tilt = -cordic_atan(r, aa[0] * 65536, mag);
    d_roll = fshr(ag[0] * dt + 64'sd1048576, 21);
    d_pitch = fshr(ag[1] * dt + 64'sd1048576, 21);
    mdl_roll_est = blend_est(roll_tilt, mdl_roll_est, d_roll);
    mdl_pitch_est = blend_est(pitch_tilt, mdl_pitch_est, d_pitch);
    res.roll = est_to_q13(mdl_roll_est);
    res.pitch = est_to_q13(mdl_pitch_est);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    n_errors++;
    $display("ERROR t=%0t transfer %0d %s: got %0d, want %0d", $realtime, n_checked,
             what, $signed(got), $signed(want));
  endtask

  // ---------------------------------------------------------------------
  // Driver: slave side, random gaps, hold while the stimulus asks for it
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      drv_gap       <= 0;
      n_sent        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_angles.push_back(filter_step(sample_t'(s_axis_tdata)));
        n_sent <= n_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        // the current transfer (if any) is done; pick the next one
        if (drv_gap != 0) begin
          drv_gap <= drv_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!drv_hold && pending_samples.size() != 0) begin
          s_axis_tdata  <= pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          drv_gap       <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: master side with random back-pressure
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    angles_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
      n_checked     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = angles_t'(m_axis_tdata);
        if (expected_angles.size() == 0) begin
          n_errors++;
          $display("ERROR t=%0t unexpected result transfer roll=%0d pitch=%0d",
                   $realtime, $signed(got.roll), $signed(got.pitch));
        end else begin
          want = expected_angles.pop_front();
          if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
          if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
        end
        n_checked <= n_checked + 1;
      end
      if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // APB register writes; predictor shadow updated at the access edge
  // ---------------------------------------------------------------------
  task automatic reg_write(input reg_idx_e idx, input logic [63:0] val);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= 6'(8 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegAlignRow0: mdl_rows[0] = val[47:0];
      RegAlignRow1: mdl_rows[1] = val[47:0];
      RegAlignRow2: mdl_rows[2] = val[47:0];
      RegGyroBias:  mdl_bias = val[47:0];
      RegBlendW:    mdl_alpha = val[15:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait until every result has come and the back end has drained
  // (sampled at the falling edge so the driver's updates have settled)
  task automatic wait_idle();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_angles.size() != 0)
      @(negedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input logic [15:0] gx,
                             input logic [15:0] gy, input logic [15:0] gz,
                             input logic [15:0] dt);
    sample_t s;
    s = '{time_step: dt, rate_z: gz, rate_y: gy, rate_x: gx,
          acc_z: az, acc_y: ay, acc_x: ax};
    pending_samples.push_back(s);
  endtask

  function automatic logic [15:0] rnd_field();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h8000;
    if (p == 1) return 16'h7FFF;
    if (p < 4) return 16'($urandom_range(0, 400)) - 16'd200;
    return 16'($urandom);
  endfunction

  // a row: mostly small rotations/permutations, sometimes anything
  function automatic logic [47:0] rnd_row(input int k);
    logic [47:0] r;
    int unsigned p;
    p = $urandom_range(0, 3);
    r = '0;
    if (p == 0) begin
      r = {16'($urandom), 16'($urandom), 16'($urandom)};
    end else begin
      r[16*k +: 16] = ($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000;
      r[16*((k+1)%3) +: 16] = 16'($urandom_range(0, 2000)) - 16'd1000;
    end
    return r;
  endfunction

  task automatic random_phase(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      // acc and gyro fields random or extreme, dt mostly 0..2000
      push_sample(rnd_field(), rnd_field(), rnd_field(), rnd_field(),
                  rnd_field(), rnd_field(),
                  ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    drv_hold = 1'b0;
    n_errors = 0;
    mdl_rows[0] = 48'h0000_0000_4000;
    mdl_rows[1] = 48'h0000_4000_0000;
    mdl_rows[2] = 48'h4000_0000_0000;
    mdl_bias = '0;
    mdl_alpha = 16'd6554;
    mdl_roll_est = 0;
    mdl_pitch_est = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset configuration
    push_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);       // zero vector
    push_sample(16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd100);  // atan2(0, neg) = pi
    push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    // left half plane, y<0
    push_sample(16'd100, 16'hFF00, 16'hF000, 16'd300, 16'hFE00, 16'd5, 16'd1000);
    // left half plane, y>0
    push_sample(16'hFF00, 16'd200, 16'hF000, 16'd0, 16'd0, 16'd0, 16'd10);
    push_sample(16'd0, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    push_sample(16'd4096, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    wait_idle();

    // alpha extremes: pure gyro integration, then pure accelerometer
    reg_write(RegBlendW, 64'h0);
    reg_write(RegGyroBias, 64'({16'h0000, 16'h8000, 16'h7FFF}));
    reg_write(RegUndef, 64'hFFFF_FFFF_FFFF_FFFF);  // ignored
    for (int i = 0; i < 6; i++)  // drive the output angles to saturation
      push_sample(16'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'd0, 16'hFFFF);
    push_sample(16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'd0, 16'hFFFF);
    wait_idle();
    reg_write(RegBlendW, 64'hFFFF_FFFF_FFFF_FFFF);  // upper bits dropped
    reg_write(RegGyroBias, 64'h0);
    push_sample(16'd0, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd50);
    push_sample(16'h8000, 16'd0, 16'h0001, 16'd0, 16'd0, 16'd0, 16'd50);
    push_sample(16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd50);
    wait_idle();

    // random phases over several matrix / bias / alpha settings
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(RegAlignRow0, {16'($urandom), rnd_row(0)});
      reg_write(RegAlignRow1, {16'($urandom), rnd_row(1)});
      reg_write(RegAlignRow2, {16'($urandom), rnd_row(2)});
      reg_write(RegGyroBias, (ph % 2 == 0) ? 64'({16'($urandom), 16'($urandom),
                                                  16'($urandom)})
                                           : 64'(16'($urandom_range(0, 64))));
      case (ph)
        0: reg_write(RegBlendW, 64'h0);
        1: reg_write(RegBlendW, 64'hFFFF);
        2: reg_write(RegBlendW, 64'd6554);
        default: reg_write(RegBlendW, 64'($urandom));
      endcase
      random_phase(50);
      while (pending_samples.size() != 0 || s_axis_tvalid) @(negedge clk_i);
      // sender holds off until every expected result has come
      drv_hold = 1'b1;
      random_phase(50);
      while (expected_angles.size() != 0) @(negedge clk_i);
      drv_hold = 1'b0;
      wait_idle();
    end

    $display("Covered %0d samples: zero and negative-axis vectors, estimate saturation,",
             n_sent);
    $display("alpha 0/max, undefined register write, random alignments and biases.");
    if (n_errors == 0) begin
      $display("imu_roll_pitch_complementary_top: match");
    end else begin
      $display("imu_roll_pitch_complementary_top: mismatch");
    end
    $finish;
  end

  // worst case: ~850 samples, each with a long gap and back-pressure
  initial begin
    #(12 * 2_000_000);
    $display("Timeout after %0d results", n_checked);
    $display("imu_roll_pitch_complementary_top: mismatch");
    $finish;
  end

endmodule
